// File: rtl/temm_pkg.sv
`timescale 1ns / 1ps
package temm_pkg;

  localparam int SAMPLE_BITS      = 24;
  localparam int DEF_NUM_TASKS    = 4;
  localparam int DEF_WINDOW_DEPTH = 100;
  localparam int TASK_W           = 2;
  localparam int CNT_W            = 32;
  localparam int MEAN_W           = 32;
  localparam int STD_W            = 28;
  localparam int DL_W             = 14;
  localparam int NUM_REGS         = 4;
  localparam int PADDR_W          = 4;
  localparam int DIV_W            = 64;
  localparam int DSR_W            = 32;
  localparam int ROOT_W           = 32;

  localparam logic [SAMPLE_BITS-1:0] US_PER_MS = SAMPLE_BITS'(1000);
  localparam logic [STD_W-1:0]       STD_MAX   = '1;
  localparam logic [CNT_W-1:0]       CNT_MAX   = '1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPD,
    ST_MDIV,
    ST_WALK,
    ST_VDIV,
    ST_SQRT,
    ST_DONE
  } temm_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } temm_unit_sts_t;

endpackage

// File: rtl/temm_div.sv
`timescale 1ns / 1ps
module temm_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [temm_pkg::DIV_W-1:0]  dividend,
  input  logic [temm_pkg::DSR_W-1:0]  divisor,
  output logic [temm_pkg::DIV_W-1:0]  quotient,
  output temm_pkg::temm_unit_sts_t    sts
);
  import temm_pkg::*;

  localparam int CW = $clog2(DIV_W + 1);

  logic              busy_r, done_r;
  logic [CW-1:0]     cnt_r;
  logic [DSR_W-1:0]  rem_r, dsr_r;
  logic [DIV_W-1:0]  quo_r;
  logic [DSR_W:0]    rem_sh;
  logic              ge;

  // One quotient bit a cycle, restoring form
  always_comb begin
    rem_sh = {rem_r, quo_r[DIV_W-1]};
    ge     = rem_sh >= {1'b0, dsr_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(DIV_W);
        rem_r  <= '0;
        quo_r  <= dividend;
        dsr_r  <= divisor;
      end else if (busy_r) begin
        rem_r <= ge ? DSR_W'(rem_sh - {1'b0, dsr_r}) : DSR_W'(rem_sh);
        quo_r <= {quo_r[DIV_W-2:0], ge};
        cnt_r <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign quotient = quo_r;
  assign sts      = '{busy: busy_r, done: done_r};

endmodule

// File: rtl/temm_sqrt.sv
`timescale 1ns / 1ps
module temm_sqrt (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [temm_pkg::DIV_W-1:0]  radicand,
  output logic [temm_pkg::ROOT_W-1:0] root,
  output temm_pkg::temm_unit_sts_t    sts
);
  import temm_pkg::*;

  localparam int CW = $clog2(ROOT_W + 1);
  localparam int RW = ROOT_W + 2;

  logic              busy_r, done_r;
  logic [CW-1:0]     cnt_r;
  logic [DIV_W-1:0]  v_r;
  logic [RW-1:0]     rem_r;
  logic [ROOT_W-1:0] root_r;
  logic [RW+1:0]     rem_sh, trial;
  logic              ge;

  // One root bit a cycle: bring down two radicand bits, try 4r+1
  always_comb begin
    rem_sh = {rem_r, v_r[DIV_W-1 -: 2]};
    trial  = {2'b00, root_r, 2'b01};
    ge     = rem_sh >= trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(ROOT_W);
        v_r    <= radicand;
        rem_r  <= '0;
        root_r <= '0;
      end else if (busy_r) begin
        rem_r  <= ge ? RW'(rem_sh - trial) : RW'(rem_sh);
        root_r <= {root_r[ROOT_W-2:0], ge};
        v_r    <= {v_r[DIV_W-3:0], 2'b00};
        cnt_r  <= cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign root = root_r;
  assign sts  = '{busy: busy_r, done: done_r};

endmodule

// File: rtl/task_execution_time_monitor.sv
`timescale 1ns / 1ps
// Channel   | Ports                         | Moves
// ----------+-------------------------------+----------------------------------
// in        | in_valid/in_ready, in_*       | one item: task index, exec time
// out       | out_valid/out_ready, out_*    | one item: the task's statistics
// cfg       | cfg_psel..cfg_pready (APB)    | per-task deadline registers
//
// The shared serial divider first runs 64 steps for the mean. With at least two
// samples in the window, the window walk then reads one entry a cycle from the
// sample memory, the divider runs 64 steps for the variance, and the serial
// square root 32 steps. in_ready is high only in idle.
// A finished item waits in the output register; the next item may be taken meanwhile.
// Reset is synchronous, active low; the sample memory needs no clearing pass.
module task_execution_time_monitor #(
  parameter int NUM_TASKS    = temm_pkg::DEF_NUM_TASKS,
  parameter int WINDOW_DEPTH = temm_pkg::DEF_WINDOW_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input items
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [temm_pkg::TASK_W-1:0]        in_task_index,
  input  logic [temm_pkg::SAMPLE_BITS-1:0]   in_execution_us,
  // result items
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [temm_pkg::CNT_W-1:0]         out_samples_seen,
  output logic [temm_pkg::SAMPLE_BITS-1:0]   out_min_time_us,
  output logic [temm_pkg::SAMPLE_BITS-1:0]   out_max_time_us,
  output logic [temm_pkg::MEAN_W-1:0]        out_mean_time_q8,
  output logic [temm_pkg::STD_W-1:0]         out_std_dev_q4,
  output logic [temm_pkg::CNT_W-1:0]         out_deadline_misses,
  output logic [temm_pkg::SAMPLE_BITS-1:0]   out_worst_overrun,
  output logic                               out_deadline_missed,
  output logic                               out_high_load,
  // configuration
  input  logic                               cfg_psel,
  input  logic                               cfg_penable,
  input  logic                               cfg_pwrite,
  input  logic [temm_pkg::PADDR_W-1:0]       cfg_paddr,
  input  logic [31:0]                        cfg_pwdata,
  output logic [31:0]                        cfg_prdata,
  output logic                               cfg_pready
);
  import temm_pkg::*;

  localparam int TW    = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
  localparam int IW    = $clog2(WINDOW_DEPTH);
  localparam int FW    = $clog2(WINDOW_DEPTH + 1);
  localparam int DEPTH = NUM_TASKS * WINDOW_DEPTH;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RIW   = $clog2(NUM_REGS);
  localparam logic [AW-1:0]     WD_A   = AW'(WINDOW_DEPTH);
  localparam logic [IW-1:0]     HEAD_L = IW'(WINDOW_DEPTH - 1);
  localparam logic [FW-1:0]     FILL_L = FW'(WINDOW_DEPTH);
  localparam logic [TASK_W:0]   NT     = (TASK_W + 1)'(NUM_TASKS);

  // Configuration: deadlines in ms
  logic [DL_W-1:0] dl_r [NUM_REGS];
  logic [RIW-1:0]  cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_idx    = cfg_paddr[RIW+1:2];
  assign cfg_prdata = 32'(dl_r[cfg_idx]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_REGS; i++) dl_r[i] <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      dl_r[cfg_idx] <= cfg_pwdata[DL_W-1:0];
    end
  end

  // Per-task statistics
  logic [IW-1:0]          head_r [NUM_TASKS];
  logic [FW-1:0]          fill_r [NUM_TASKS];
  logic [CNT_W-1:0]       cnt_r  [NUM_TASKS];
  logic [SAMPLE_BITS-1:0] min_r  [NUM_TASKS];
  logic [SAMPLE_BITS-1:0] max_r  [NUM_TASKS];
  logic [MEAN_W-1:0]      mean_r [NUM_TASKS];
  logic [STD_W-1:0]       std_r  [NUM_TASKS];
  logic [CNT_W-1:0]       miss_r [NUM_TASKS];
  logic [SAMPLE_BITS-1:0] ovr_r  [NUM_TASKS];

  // Current item
  temm_state_t            state_r, state_nxt;
  logic [TW-1:0]          t_r;
  logic                   bad_r;
  logic [SAMPLE_BITS-1:0] x_r;
  logic [SAMPLE_BITS-1:0] dlus_r;
  logic                   mdir_r;
  logic                   missed_r, high_r;

  // Window walk pipeline: read, difference, square, accumulate
  logic [FW-1:0]          rd_idx_r;
  logic                   v1_r, v2_r, v3_r;
  logic [SAMPLE_BITS-1:0] mem_q_r;
  logic [STD_W-1:0]       e_r;
  logic [2*STD_W-1:0]     prod_r;
  logic [DIV_W-1:0]       sum_r;

  logic [SAMPLE_BITS-1:0] win_mem [DEPTH];

  // Shared units
  logic                   div_go, sqrt_go;
  logic [DIV_W-1:0]       div_dvd, div_q;
  logic [DSR_W-1:0]       div_dsr;
  logic [ROOT_W-1:0]      root;
  temm_unit_sts_t         div_sts, sqrt_sts;

  // Combinational helpers
  logic [CNT_W-1:0]       cnt_inc;
  logic [MEAN_W-1:0]      xq, mean_cur, dmag;
  logic                   mge;
  logic [STD_W-1:0]       s16, m4;
  logic                   walk_done, walk_issue;
  logic [AW-1:0]          wr_addr, rd_addr;
  logic [SAMPLE_BITS-1:0] over;
  logic                   in_acc;

  assign in_acc   = in_valid && in_ready;
  assign cnt_inc  = (cnt_r[t_r] == CNT_MAX) ? CNT_MAX : cnt_r[t_r] + CNT_W'(1);
  assign xq       = {x_r, 8'h00};
  assign mean_cur = mean_r[t_r];
  assign mge      = xq >= mean_cur;
  assign dmag     = mge ? xq - mean_cur : mean_cur - xq;
  assign over     = x_r - dlus_r;

  assign s16 = {mem_q_r, 4'h0};
  assign m4  = mean_cur[MEAN_W-1:4];

  assign walk_issue = rd_idx_r < fill_r[t_r];
  assign walk_done  = !walk_issue && !v1_r && !v2_r && !v3_r;
  assign wr_addr    = AW'(t_r) * WD_A + AW'(head_r[t_r]);
  assign rd_addr    = AW'(t_r) * WD_A + AW'(rd_idx_r);

  assign div_dvd = (state_r == ST_UPD) ? DIV_W'(dmag) : sum_r;
  assign div_dsr = (state_r == ST_UPD) ? cnt_inc : DSR_W'(fill_r[t_r]);

  temm_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_go),
    .dividend (div_dvd),
    .divisor  (div_dsr),
    .quotient (div_q),
    .sts      (div_sts)
  );

  temm_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (sqrt_go),
    .radicand (div_q),
    .root     (root),
    .sts      (sqrt_sts)
  );

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_valid) state_nxt = (in_task_index >= NT) ? ST_DONE : ST_UPD;
      ST_UPD:  state_nxt = ST_MDIV;
      ST_MDIV: if (div_sts.done) state_nxt = (fill_r[t_r] >= FW'(2)) ? ST_WALK : ST_DONE;
      ST_WALK: if (walk_done) state_nxt = ST_VDIV;
      ST_VDIV: if (div_sts.done) state_nxt = ST_SQRT;
      ST_SQRT: if (sqrt_sts.done) state_nxt = ST_DONE;
      ST_DONE: if (!out_valid || out_ready) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control strobes
  always_comb begin
    in_ready = 1'b0;
    div_go   = 1'b0;
    sqrt_go  = 1'b0;
    case (state_r)
      ST_IDLE: in_ready = 1'b1;
      ST_UPD:  div_go   = 1'b1;
      ST_WALK: div_go   = walk_done;
      ST_VDIV: sqrt_go  = div_sts.done;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else        state_r <= state_nxt;
  end

  // Sample memory: one write, one registered read
  always_ff @(posedge clk) begin
    if (state_r == ST_UPD) win_mem[wr_addr] <= x_r;
    mem_q_r <= win_mem[rd_addr];
  end

  // Item capture and statistics update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_TASKS; i++) begin
        head_r[i] <= '0;
        fill_r[i] <= '0;
        cnt_r[i]  <= '0;
        min_r[i]  <= '1;
        max_r[i]  <= '0;
        mean_r[i] <= '0;
        std_r[i]  <= '0;
        miss_r[i] <= '0;
        ovr_r[i]  <= '0;
      end
      bad_r <= 1'b0;
      v1_r  <= 1'b0;
      v2_r  <= 1'b0;
      v3_r  <= 1'b0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            // hold the item and its deadline in us
            t_r      <= TW'(in_task_index);
            bad_r    <= in_task_index >= NT;
            x_r      <= in_execution_us;
            dlus_r   <= SAMPLE_BITS'(dl_r[in_task_index[RIW-1:0]]) * US_PER_MS;
          end
        end
        ST_UPD: begin
          cnt_r[t_r]  <= cnt_inc;
          if (x_r < min_r[t_r]) min_r[t_r] <= x_r;
          if (x_r > max_r[t_r]) max_r[t_r] <= x_r;
          head_r[t_r] <= (head_r[t_r] == HEAD_L) ? '0 : head_r[t_r] + IW'(1);
          if (fill_r[t_r] < FILL_L) fill_r[t_r] <= fill_r[t_r] + FW'(1);
          mdir_r   <= mge;
          missed_r <= (dlus_r != '0) && (x_r > dlus_r);
          high_r   <= (dlus_r != '0) &&
                      ({x_r, 2'b00} + (SAMPLE_BITS + 3)'(x_r)) > {1'b0, dlus_r, 2'b00};
          if ((dlus_r != '0) && (x_r > dlus_r)) begin
            if (miss_r[t_r] != CNT_MAX) miss_r[t_r] <= miss_r[t_r] + CNT_W'(1);
            if (over > ovr_r[t_r]) ovr_r[t_r] <= over;
          end
          rd_idx_r <= '0;
          sum_r    <= '0;
          v1_r     <= 1'b0;
          v2_r     <= 1'b0;
          v3_r     <= 1'b0;
        end
        ST_MDIV: begin
          if (div_sts.done) begin
            mean_r[t_r] <= mdir_r ? mean_cur + div_q[MEAN_W-1:0]
                                  : mean_cur - div_q[MEAN_W-1:0];
          end
        end
        ST_WALK: begin
          // advance the walk one entry a cycle
          v1_r <= walk_issue;
          if (walk_issue) rd_idx_r <= rd_idx_r + FW'(1);
          v2_r   <= v1_r;
          e_r    <= (s16 >= m4) ? s16 - m4 : m4 - s16;
          v3_r   <= v2_r;
          prod_r <= e_r * e_r;
          if (v3_r) sum_r <= sum_r + DIV_W'(prod_r);
        end
        ST_SQRT: begin
          if (sqrt_sts.done) begin
            std_r[t_r] <= (root > ROOT_W'(STD_MAX)) ? STD_MAX : root[STD_W-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  // Output register: load when the slot is free or being emptied
  logic out_valid_r, out_load;
  assign out_load  = (state_r == ST_DONE) && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (bad_r) begin
        // drop all fields for a task out of range
        out_samples_seen     <= '0;
        out_min_time_us      <= '0;
        out_max_time_us      <= '0;
        out_mean_time_q8     <= '0;
        out_std_dev_q4       <= '0;
        out_deadline_misses  <= '0;
        out_worst_overrun    <= '0;
        out_deadline_missed  <= 1'b0;
        out_high_load        <= 1'b0;
      end else begin
        out_samples_seen     <= cnt_r[t_r];
        out_min_time_us      <= min_r[t_r];
        out_max_time_us      <= max_r[t_r];
        out_mean_time_q8     <= mean_r[t_r];
        out_std_dev_q4       <= std_r[t_r];
        out_deadline_misses  <= miss_r[t_r];
        out_worst_overrun    <= ovr_r[t_r];
        out_deadline_missed  <= missed_r;
        out_high_load        <= high_r;
      end
    end
  end

endmodule

// File: verif/task_execution_time_monitor_test.sv
`timescale 1ns / 1ps
module task_execution_time_monitor_test;
  import temm_pkg::*;

  localparam int TASKS      = 4;
  localparam int DEPTH      = 100;
  localparam int LIMIT      = 1000000;
  localparam int DRAIN_WAIT = 400;
  localparam int LONG_HOLD  = 3000;

  // deadline register indexes, one per task
  typedef enum int {
    REG_DEADLINE_T0 = 0,
    REG_DEADLINE_T1 = 1,
    REG_DEADLINE_T2 = 2,
    REG_DEADLINE_T3 = 3
  } reg_index_t;

  // receiver behaviour between reconfigurations
  typedef enum int {
    RX_ALWAYS,
    RX_COIN,
    RX_SLUGGISH
  } rx_mode_t;

  typedef struct packed {
    logic [CNT_W-1:0]       samples_seen;
    logic [SAMPLE_BITS-1:0] min_time_us;
    logic [SAMPLE_BITS-1:0] max_time_us;
    logic [MEAN_W-1:0]      mean_time_q8;
    logic [STD_W-1:0]       std_dev_q4;
    logic [CNT_W-1:0]       deadline_misses;
    logic [SAMPLE_BITS-1:0] worst_overrun;
    logic                   deadline_missed;
    logic                   high_load;
  } task_stats_t;

  typedef struct {
    logic [TASK_W-1:0]      task_id;
    logic [SAMPLE_BITS-1:0] exec_us;
    bit                     typed;
    task_stats_t            stats;
  } probe_row_t;

  logic clk, rst_n;
  logic in_valid, in_ready;
  logic [TASK_W-1:0]      in_task_index;
  logic [SAMPLE_BITS-1:0] in_execution_us;
  logic out_valid, out_ready;
  logic [CNT_W-1:0]       out_samples_seen;
  logic [SAMPLE_BITS-1:0] out_min_time_us;
  logic [SAMPLE_BITS-1:0] out_max_time_us;
  logic [MEAN_W-1:0]      out_mean_time_q8;
  logic [STD_W-1:0]       out_std_dev_q4;
  logic [CNT_W-1:0]       out_deadline_misses;
  logic [SAMPLE_BITS-1:0] out_worst_overrun;
  logic                   out_deadline_missed;
  logic                   out_high_load;
  logic                   cfg_psel, cfg_penable, cfg_pwrite;
  logic [PADDR_W-1:0]     cfg_paddr;
  logic [31:0]            cfg_pwdata, cfg_prdata;
  logic                   cfg_pready;

  task_execution_time_monitor DUT (.*);

  // Shadow of the block's per-task statistics
  logic [DL_W-1:0]        deadline_ms_q [TASKS];
  logic [SAMPLE_BITS-1:0] window_q      [TASKS][DEPTH];
  int unsigned            head_q        [TASKS];
  int unsigned            fill_q        [TASKS];
  logic [CNT_W-1:0]       count_q       [TASKS];
  logic [SAMPLE_BITS-1:0] min_q         [TASKS];
  logic [SAMPLE_BITS-1:0] max_q         [TASKS];
  logic [63:0]            mean_q        [TASKS];
  logic [STD_W-1:0]       std_q         [TASKS];
  logic [CNT_W-1:0]       misses_q      [TASKS];
  logic [SAMPLE_BITS-1:0] overrun_q     [TASKS];

  task_stats_t stats_due[$];
  int          mismatches;
  bit          failed;
  int unsigned cycle_count;
  bit          long_hold_req;

  // Integer square root, digit by digit
  function automatic logic [63:0] root_floor(logic [63:0] v);
    logic [63:0] res, bit_w;
    res   = 0;
    bit_w = 64'd1 << 62;
    while (bit_w > v) bit_w = bit_w >> 2;
    while (bit_w != 0) begin
      if (v >= res + bit_w) begin
        v   = v - (res + bit_w);
        res = (res >> 1) + bit_w;
      end else begin
        res = res >> 1;
      end
      bit_w = bit_w >> 2;
    end
    return res;
  endfunction

  // Spread of the window about the lifetime mean, Q.4
  function automatic logic [STD_W-1:0] window_spread(int t);
    logic [63:0] m4, s16, e, sum, r;
    m4  = mean_q[t] >> 4;
    sum = 0;
    for (int i = 0; i < fill_q[t]; i++) begin
      s16 = {36'd0, window_q[t][i], 4'd0};
      e   = (s16 >= m4) ? s16 - m4 : m4 - s16;
      sum = sum + e * e;
    end
    r = root_floor(sum / fill_q[t]);
    return (r > STD_MAX) ? STD_MAX : r[STD_W-1:0];
  endfunction

  // Fold one sample into the shadow and return the statistics it yields
  function automatic task_stats_t account_sample(int t, logic [SAMPLE_BITS-1:0] x);
    task_stats_t s;
    logic [63:0] xq, q, dl_us;
    s = '0;
    if (count_q[t] != CNT_MAX) count_q[t] = count_q[t] + 1;
    if (x < min_q[t]) min_q[t] = x;
    if (x > max_q[t]) max_q[t] = x;
    window_q[t][head_q[t]] = x;
    head_q[t] = (head_q[t] + 1) % DEPTH;
    if (fill_q[t] < DEPTH) fill_q[t]++;
    xq = {32'd0, x, 8'd0};
    if (xq >= mean_q[t]) begin
      q = (xq - mean_q[t]) / count_q[t];
      mean_q[t] = mean_q[t] + q;
    end else begin
      q = (mean_q[t] - xq) / count_q[t];
      mean_q[t] = mean_q[t] - q;
    end
    if (fill_q[t] >= 2) std_q[t] = window_spread(t);
    dl_us = 64'(deadline_ms_q[t]) * 1000;
    if (dl_us != 0) begin
      if (64'(x) > dl_us) begin
        s.deadline_missed = 1'b1;
        if (misses_q[t] != CNT_MAX) misses_q[t] = misses_q[t] + 1;
        if (64'(x) - dl_us > 64'(overrun_q[t])) overrun_q[t] = SAMPLE_BITS'(64'(x) - dl_us);
      end
      s.high_load = (64'(x) * 5 > dl_us * 4);
    end
    s.samples_seen     = count_q[t];
    s.min_time_us      = min_q[t];
    s.max_time_us      = max_q[t];
    s.mean_time_q8     = (mean_q[t] > 64'(CNT_MAX)) ? CNT_MAX : mean_q[t][31:0];
    s.std_dev_q4       = std_q[t];
    s.deadline_misses  = misses_q[t];
    s.worst_overrun    = overrun_q[t];
    return s;
  endfunction

  // Clock: 10 ns period
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop if the run hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT) begin
      $display("task_execution_time_monitor_test NOT OK");
      $finish;
    end
  end

  // Receiver: a ready pattern of its own, with one long hold-off on request
  initial begin
    rx_mode_t    mode;
    int unsigned left;
    out_ready = 1'b0;
    mode      = RX_ALWAYS;
    left      = 0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        out_ready = 1'b0;
        repeat (LONG_HOLD - 1) @(negedge clk);
        long_hold_req = 1'b0;
      end else begin
        if (left == 0) begin
          mode = rx_mode_t'($urandom_range(2, 0));
          left = $urandom_range(200, 20);
        end
        left--;
        case (mode)
          RX_ALWAYS: out_ready = 1'b1;
          RX_COIN:   out_ready = 1'($urandom_range(1, 0));
          default:   out_ready = ($urandom_range(4, 0) == 0);
        endcase
      end
    end
  end

  // Compare one field, report the first few mismatches
  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      failed = 1'b1;
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s: expected %0d, got %0d", name, want, got);
    end
  endtask

  // Check each result item against the oldest expectation
  always @(posedge clk) begin
    task_stats_t want;
    if (rst_n && out_valid && out_ready) begin
      if (stats_due.size() == 0) begin
        failed = 1'b1;
        mismatches++;
        if (mismatches <= 10) $display("result item with nothing expected");
      end else begin
        want = stats_due.pop_front();
        check_field("samples_seen",     want.samples_seen,     out_samples_seen);
        check_field("min_time_us",      want.min_time_us,      out_min_time_us);
        check_field("max_time_us",      want.max_time_us,      out_max_time_us);
        check_field("mean_time_q8",     want.mean_time_q8,     out_mean_time_q8);
        check_field("std_dev_q4",       want.std_dev_q4,       out_std_dev_q4);
        check_field("deadline_misses",  want.deadline_misses,  out_deadline_misses);
        check_field("worst_overrun",    want.worst_overrun,    out_worst_overrun);
        check_field("deadline_missed",  want.deadline_missed,  out_deadline_missed);
        check_field("high_load",        want.high_load,        out_high_load);
      end
    end
  end

  // Write one deadline register: setup then access phase
  task automatic write_deadline(reg_index_t idx, logic [DL_W-1:0] ms);
    @(negedge clk);
    cfg_psel    = 1'b1;
    cfg_penable = 1'b0;
    cfg_pwrite  = 1'b1;
    cfg_paddr   = PADDR_W'(int'(idx) * 4);
    cfg_pwdata  = 32'(ms);
    @(negedge clk);
    cfg_penable = 1'b1;
    do @(posedge clk); while (!cfg_pready);
    deadline_ms_q[idx] = ms;
    @(negedge clk);
    cfg_psel    = 1'b0;
    cfg_penable = 1'b0;
  endtask

  // Offer one item and hold it until accepted; queue its expectation
  task automatic send_item(logic [TASK_W-1:0] t, logic [SAMPLE_BITS-1:0] x,
                           bit typed, task_stats_t typed_stats);
    task_stats_t s;
    @(negedge clk);
    in_valid        = 1'b1;
    in_task_index   = t;
    in_execution_us = x;
    do @(posedge clk); while (!in_ready);
    s = account_sample(t, x);
    stats_due.insert(stats_due.size(), typed ? typed_stats : s);
  endtask

  // Drop valid for a number of falling edges
  task automatic idle_sender(int unsigned gap);
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Hold off new items until every expected result has come, then settle
  task automatic drain_block();
    idle_sender(1);
    while (stats_due.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // Pick a sample: often near the task's deadline, else small, anywhere or an extreme
  function automatic logic [SAMPLE_BITS-1:0] pick_sample(int t);
    int unsigned dl_us, lo, hi;
    dl_us = deadline_ms_q[t] * 1000;
    case ($urandom_range(9, 0))
      0, 1, 2: return SAMPLE_BITS'($urandom());
      3, 4:    return SAMPLE_BITS'($urandom_range(5000, 0));
      9:       return ($urandom_range(1, 0) != 0) ? '1 : '0;
      default: begin
        if (dl_us == 0) return SAMPLE_BITS'($urandom_range(100000, 0));
        lo = (dl_us > 2000) ? (dl_us * 4 / 5) - 2000 : 0;
        hi = dl_us + 2000;
        if (hi > 24'hFFFFFF) hi = 24'hFFFFFF;
        return SAMPLE_BITS'($urandom_range(hi, lo));
      end
    endcase
  endfunction

  probe_row_t directed_rows[$];

  initial begin
    task_stats_t none;
    probe_row_t  row;
    int unsigned sent, burst;

    // Drive every input from time zero with reset held low
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_task_index   = '0;
    in_execution_us = '0;
    cfg_psel        = 1'b0;
    cfg_penable     = 1'b0;
    cfg_pwrite      = 1'b0;
    cfg_paddr       = '0;
    cfg_pwdata      = '0;
    long_hold_req   = 1'b0;
    mismatches      = 0;
    failed          = 1'b0;
    cycle_count     = 0;
    none            = '0;
    for (int t = 0; t < TASKS; t++) begin
      deadline_ms_q[t] = '0;
      head_q[t]        = 0;
      fill_q[t]        = 0;
      count_q[t]       = '0;
      min_q[t]         = '1;
      max_q[t]         = '0;
      mean_q[t]        = '0;
      std_q[t]         = '0;
      misses_q[t]      = '0;
      overrun_q[t]     = '0;
    end
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Deadlines: none, the largest, 1 ms and 5 ms
    write_deadline(REG_DEADLINE_T0, 14'd0);
    write_deadline(REG_DEADLINE_T1, 14'd16383);
    write_deadline(REG_DEADLINE_T2, 14'd1);
    write_deadline(REG_DEADLINE_T3, 14'd5);

    // Directed rows; typed expectations where they are plain to read
    row = '{2'd0, 24'd0, 1'b1, '{32'd1, 24'd0, 24'd0, 32'd0, 28'd0,
                                  32'd0, 24'd0, 1'b0, 1'b0}};
    directed_rows.insert(directed_rows.size(), row);
    row = '{2'd1, 24'hFFFFFF, 1'b1, '{32'd1, 24'hFFFFFF, 24'hFFFFFF, 32'hFFFFFF00,
                                      28'd0, 32'd1, 24'd394215, 1'b1, 1'b1}};
    directed_rows.insert(directed_rows.size(), row);
    // just under, at and over the 1 ms deadline, and at and just over its 80% mark
    row = '{2'd2, 24'd800,  1'b1, '{32'd1, 24'd800, 24'd800, 32'd204800, 28'd0,
                                    32'd0, 24'd0, 1'b0, 1'b0}};
    directed_rows.insert(directed_rows.size(), row);
    begin
      logic [SAMPLE_BITS-1:0] probes [$];
      probes = '{24'd801, 24'd1000, 24'd1001, 24'd0, 24'hFFFFFF, 24'd999};
      foreach (probes[i]) begin
        row = '{2'd2, probes[i], 1'b0, none};
        directed_rows.insert(directed_rows.size(), row);
      end
      probes = '{24'd4000, 24'd4001, 24'd5000, 24'd5001, 24'd123456, 24'd1};
      foreach (probes[i]) begin
        row = '{2'd3, probes[i], 1'b0, none};
        directed_rows.insert(directed_rows.size(), row);
      end
      probes = '{24'hFFFFFF, 24'd16383000, 24'd16383001, 24'd0};
      foreach (probes[i]) begin
        row = '{2'd1, probes[i], 1'b0, none};
        directed_rows.insert(directed_rows.size(), row);
      end
      probes = '{24'hFFFFFF, 24'h555555, 24'hAAAAAA, 24'd7};
      foreach (probes[i]) begin
        row = '{2'd0, probes[i], 1'b0, none};
        directed_rows.insert(directed_rows.size(), row);
      end
    end
    foreach (directed_rows[i]) begin
      send_item(directed_rows[i].task_id, directed_rows[i].exec_us,
                directed_rows[i].typed, directed_rows[i].stats);
      idle_sender($urandom_range(3, 0));
    end
    drain_block();

    // Random phases, each under fresh deadlines; extremes in the first two
    for (int phase = 0; phase < 4; phase++) begin
      for (int t = 0; t < TASKS; t++) begin
        logic [DL_W-1:0] ms;
        case (phase)
          0:       ms = (t % 2 == 0) ? '1 : 14'd0;
          1:       ms = (t % 2 == 0) ? 14'd0 : '1;
          default: ms = ($urandom_range(3, 0) == 0) ? 14'd0
                                                    : DL_W'($urandom_range(16383, 1));
        endcase
        write_deadline(reg_index_t'(t), ms);
      end
      // Starve the block of a receiver for a while during one phase
      if (phase == 2) long_hold_req = 1'b1;
      sent = 0;
      while (sent < 120) begin
        burst = $urandom_range(12, 1);
        repeat (burst) begin
          int t;
          t = $urandom_range(TASKS - 1, 0);
          send_item(TASK_W'(t), pick_sample(t), 1'b0, none);
          sent++;
        end
        idle_sender(($urandom_range(3, 0) == 0) ? 0 : $urandom_range(20, 1));
      end
      drain_block();
    end

    if (!failed) begin
      $display("task_execution_time_monitor_test OK");
    end else begin
      $display("task_execution_time_monitor_test NOT OK");
    end
    $finish;
  end

endmodule
